// File: design/ffss_pkg.sv
package ffss_pkg;

  localparam int POP_MAX_DEF    = 64;
  localparam int OBJ_MAX_DEF    = 4;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [0:0] REG_SURV_COUNT = 1'b0;
  localparam logic [0:0] REG_OBJ_USE    = 1'b1;

  localparam logic [6:0] SURV_COUNT_RESET = 7'd64;
  localparam logic [2:0] OBJ_USE_RESET    = 3'd2;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic load;        // store the accepted candidate
    logic sort_start;  // clear sort indices for a new pass
    logic sort_rd;     // issue reads of order[i] and order[j]
    logic sort_cmp;    // latch order[i] and order[j] as key read addresses
    logic sort_xchg;   // compare keys and swap when strictly out of order
    logic sort_adv;    // write the j side of a swap, advance the i/j indices
    logic sel_grp;     // 0: infeasible sort, 1: feasible sort
    logic emit_rd;     // read the order entry for the current pick
    logic emit_adv;    // move to the next pick
    logic run_clear;   // reset counts at end of run
  } ffss_cmd_t;

  // Datapath status returned to the controller
  typedef struct packed {
    logic run_done;    // last load completed the run
    logic sort_end;    // no more (i, j) pairs in this pass
    logic emit_last;   // current pick is the final one
  } ffss_sts_t;

endpackage

// File: design/ffss_if.sv
interface ffss_in_if #(
  parameter int VALUE_BITS = ffss_pkg::VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] violation;
  logic signed [VALUE_BITS-1:0] objective_0;
  logic signed [VALUE_BITS-1:0] objective_1;
  logic signed [VALUE_BITS-1:0] objective_2;
  logic signed [VALUE_BITS-1:0] objective_3;

  modport source (output valid, violation, objective_0, objective_1, objective_2,
                  objective_3, input ready);
  modport sink (input valid, violation, objective_0, objective_1, objective_2,
                objective_3, output ready);
endinterface

interface ffss_out_if ();
  logic       valid;
  logic       ready;
  logic [5:0] target_slot;
  logic [6:0] source_index;
  logic       last_of_run;

  modport source (output valid, target_slot, source_index, last_of_run, input ready);
  modport sink (input valid, target_slot, source_index, last_of_run, output ready);
endinterface

// File: design/ffss_ram.sv
module ffss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/ffss_ctrl.sv
module ffss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffss_pkg::ffss_sts_t sts,
  output ffss_pkg::ffss_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_CMP   = 11'b00000001000,
    S_KEY   = 11'b00000010000,
    S_XCHG  = 11'b00000100000,
    S_ADV   = 11'b00001000000,
    S_EMRD  = 11'b00010000000,
    S_EMWT  = 11'b00100000000,
    S_EMIT  = 11'b01000000000,
    S_START = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   grp, grp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      grp   <= 1'b0;
    end else begin
      state <= state_next;
      grp   <= grp_next;
    end
  end

  // Sequence load, two sort passes, then the picks
  always_comb begin
    state_next = state;
    grp_next   = grp;
    cmd        = '0;
    cmd.sel_grp = grp;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.run_done) begin
          grp_next   = 1'b0;
          state_next = S_START;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_START: begin
        cmd.sort_start = 1'b1;
        state_next     = S_RD;
      end
      S_RD: begin
        if (sts.sort_end) begin
          if (grp) begin
            state_next = S_EMRD;
          end else begin
            grp_next   = 1'b1;
            state_next = S_START;
          end
        end else begin
          cmd.sort_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.sort_cmp = 1'b1;
        state_next   = S_KEY;
      end
      S_KEY: begin
        state_next = S_XCHG;
      end
      S_XCHG: begin
        cmd.sort_xchg = 1'b1;
        state_next    = S_ADV;
      end
      S_ADV: begin
        cmd.sort_adv = 1'b1;
        state_next   = S_RD;
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMWT;
      end
      S_EMWT: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) begin
            cmd.run_clear = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_EMRD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

// File: design/ffss_dp.sv
module ffss_dp #(
  parameter int POP_MAX    = ffss_pkg::POP_MAX_DEF,
  parameter int OBJ_MAX    = ffss_pkg::OBJ_MAX_DEF,
  parameter int VALUE_BITS = ffss_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ffss_pkg::ffss_cmd_t          cmd,
  output ffss_pkg::ffss_sts_t          sts,
  input  logic [6:0]                   surv_count,
  input  logic [2:0]                   obj_use,
  input  logic signed [VALUE_BITS-1:0] violation,
  input  logic signed [VALUE_BITS-1:0] objective_0,
  input  logic signed [VALUE_BITS-1:0] objective_1,
  input  logic signed [VALUE_BITS-1:0] objective_2,
  input  logic signed [VALUE_BITS-1:0] objective_3,
  output logic [5:0]                   target_slot,
  output logic [6:0]                   source_index,
  output logic                         last_of_run
);

  localparam int CAND  = 2 * POP_MAX;
  localparam int AW    = $clog2(CAND);
  localparam int CW    = AW + 1;
  localparam int FW    = VALUE_BITS + 2;
  localparam int PW    = $clog2(POP_MAX + 1);

  // Effective register values, saturated
  logic [PW-1:0] p_eff;
  logic [2:0]    k_eff;
  always_comb begin
    if (surv_count == 7'd0) begin
      p_eff = PW'(1);
    end else if (32'(surv_count) > POP_MAX) begin
      p_eff = PW'(POP_MAX);
    end else begin
      p_eff = PW'(surv_count);
    end
    if (obj_use == 3'd0) begin
      k_eff = 3'd1;
    end else if (32'(obj_use) > OBJ_MAX) begin
      k_eff = 3'(OBJ_MAX);
    end else begin
      k_eff = obj_use;
    end
  end

  // Fitness of the incoming candidate
  logic signed [FW-1:0] fit_sum;
  logic [FW-1:0]        fit_abs;
  logic signed [FW-1:0] a1, a2, a3;
  always_comb begin
    a1 = objective_1[VALUE_BITS-1] ? -FW'(objective_1) : FW'(objective_1);
    a2 = objective_2[VALUE_BITS-1] ? -FW'(objective_2) : FW'(objective_2);
    a3 = objective_3[VALUE_BITS-1] ? -FW'(objective_3) : FW'(objective_3);
    fit_sum = FW'(objective_0);
    if (k_eff > 3'd1) fit_sum = fit_sum + a1;
    if (k_eff > 3'd2) fit_sum = fit_sum + a2;
    if (k_eff > 3'd3) fit_sum = fit_sum + a3;
    fit_abs = fit_sum[FW-1] ? FW'(-fit_sum) : FW'(fit_sum);
  end

  // Load counters
  logic [CW-1:0] loaded_count, infeasible_count;
  logic [AW-1:0] idx;
  logic          is_inf;
  assign idx    = (loaded_count >= CW'(CAND)) ? AW'(CAND - 1) : loaded_count[AW-1:0];
  assign is_inf = violation[VALUE_BITS-1];

  logic [CW-1:0] fea_count;
  assign fea_count = loaded_count - infeasible_count;
  assign sts.run_done = (loaded_count >= {p_eff, 1'b0});

  // Sort indices
  logic [CW-1:0] si, sj, slen;
  assign slen = cmd.sel_grp ? fea_count : infeasible_count;
  assign sts.sort_end = (CW'(si + 1'b1) >= slen);

  // Emit index
  logic [PW-1:0] pick;
  assign sts.emit_last = (pick + 1'b1 == p_eff);

  // Order stores (feasible and infeasible)
  logic          fo_we, io_we;
  logic [AW-1:0] fo_wa, io_wa, ord_ra, ord_rb;
  logic [AW-1:0] fo_wd, io_wd;
  logic [AW-1:0] fo_qa, fo_qb, io_qa, io_qb;
  logic [AW-1:0] oi, oj;
  logic          swap;

  // Key stores
  logic [VALUE_BITS-1:0] vq_a, vq_b;
  logic [FW-1:0]         fq_a, fq_b;

  // Hold port a on the pick entry except during sort reads
  always_comb begin
    ord_ra = si[AW-1:0];
    ord_rb = sj[AW-1:0];
    if (!cmd.sort_rd) begin
      if (CW'(pick) < fea_count) begin
        ord_ra = AW'(pick);
      end else begin
        ord_ra = AW'(CW'(pick) - fea_count);
      end
    end
  end

  logic swap_q;

  always_comb begin
    fo_we = 1'b0;
    io_we = 1'b0;
    fo_wa = AW'(idx - AW'(infeasible_count));
    io_wa = infeasible_count[AW-1:0];
    fo_wd = idx;
    io_wd = idx;
    if (cmd.load) begin
      fo_we = !is_inf;
      io_we = is_inf;
    end else if (cmd.sort_xchg && swap) begin
      fo_we = cmd.sel_grp;
      io_we = !cmd.sel_grp;
      fo_wa = si[AW-1:0];
      io_wa = si[AW-1:0];
      fo_wd = oj;
      io_wd = oj;
    end else if (cmd.sort_adv && swap_q) begin
      fo_we = cmd.sel_grp;
      io_we = !cmd.sel_grp;
      fo_wa = sj[AW-1:0];
      io_wa = sj[AW-1:0];
      fo_wd = oi;
      io_wd = oi;
    end
  end

  ffss_ram #(.WIDTH(AW), .DEPTH(CAND)) u_fea_ord (
    .clk(clk), .we(fo_we), .waddr(fo_wa), .wdata(fo_wd),
    .raddr_a(ord_ra), .rdata_a(fo_qa), .raddr_b(ord_rb), .rdata_b(fo_qb)
  );

  ffss_ram #(.WIDTH(AW), .DEPTH(CAND)) u_inf_ord (
    .clk(clk), .we(io_we), .waddr(io_wa), .wdata(io_wd),
    .raddr_a(ord_ra), .rdata_a(io_qa), .raddr_b(ord_rb), .rdata_b(io_qb)
  );

  ffss_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAND)) u_viol (
    .clk(clk), .we(cmd.load), .waddr(idx), .wdata(violation),
    .raddr_a(oi), .rdata_a(vq_a), .raddr_b(oj), .rdata_b(vq_b)
  );

  ffss_ram #(.WIDTH(FW), .DEPTH(CAND)) u_fit (
    .clk(clk), .we(cmd.load), .waddr(idx), .wdata(fit_abs),
    .raddr_a(oi), .rdata_a(fq_a), .raddr_b(oj), .rdata_b(fq_b)
  );

  // Exchange decision on the fetched keys
  always_comb begin
    if (cmd.sel_grp) begin
      swap = fq_a > fq_b;
    end else begin
      swap = $signed(vq_a) < $signed(vq_b);
    end
  end

  // Counters, sort and pick indices, latched swap decision
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count     <= '0;
      infeasible_count <= '0;
      si               <= '0;
      sj               <= '0;
      pick             <= '0;
      swap_q           <= 1'b0;
    end else begin
      if (cmd.load) begin
        loaded_count <= CW'(idx) + 1'b1;
        if (is_inf) infeasible_count <= infeasible_count + 1'b1;
      end
      if (cmd.sort_start) begin
        si   <= '0;
        sj   <= CW'(1);
        pick <= '0;
      end
      if (cmd.sort_xchg) swap_q <= swap;
      if (cmd.sort_adv) begin
        if (CW'(sj + 1'b1) >= slen) begin
          si <= si + 1'b1;
          sj <= si + 2'd2;
        end else begin
          sj <= sj + 1'b1;
        end
      end
      if (cmd.emit_adv) pick <= pick + 1'b1;
      if (cmd.run_clear) begin
        loaded_count     <= '0;
        infeasible_count <= '0;
      end
    end
  end

  // Capture order entries after their read
  always_ff @(posedge clk) begin
    if (cmd.sort_cmp) begin
      oi <= cmd.sel_grp ? fo_qa : io_qa;
      oj <= cmd.sel_grp ? fo_qb : io_qb;
    end
  end

  // Output fields
  logic emit_fea;
  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      emit_fea    <= (CW'(pick) < fea_count);
      target_slot <= 6'(pick);
      last_of_run <= sts.emit_last;
    end
  end
  assign source_index = 7'(emit_fea ? fo_qa : io_qa);

endmodule

// File: design/feasibility_first_survivor_select_core.sv
// A load passes through the load and check states; the last load of a run starts two
// exchange sorts over the group sizes, each pair going through the read, compare, key,
// exchange and advance states; then each pick goes through the emit read, wait and
// emit states and is held until the output takes it. No new candidate is accepted
// while the sorts and picks run on the dual-port order and key memories.
// Reset: synchronous, active high; clears counters, controller and registers
// (survivor count 64, objectives_in_use 2); memory contents stay undefined.
module feasibility_first_survivor_select_core #(
  parameter int POP_MAX    = ffss_pkg::POP_MAX_DEF,
  parameter int OBJ_MAX    = ffss_pkg::OBJ_MAX_DEF,
  parameter int VALUE_BITS = ffss_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ffss_in_if.sink     in_ch,
  ffss_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ffss_pkg::ffss_cmd_t cmd;
  ffss_pkg::ffss_sts_t sts;
  logic [6:0] surv_count;
  logic [2:0] obj_use;
  logic       wr;

  // Configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      surv_count <= ffss_pkg::SURV_COUNT_RESET;
      obj_use    <= ffss_pkg::OBJ_USE_RESET;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == ffss_pkg::REG_SURV_COUNT) surv_count <= pwdata[6:0];
      else obj_use <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == ffss_pkg::REG_SURV_COUNT) prdata = {25'd0, surv_count};
      else prdata = {29'd0, obj_use};
    end
  end

  ffss_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  ffss_dp #(.POP_MAX(POP_MAX), .OBJ_MAX(OBJ_MAX), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .surv_count(surv_count), .obj_use(obj_use),
    .violation(in_ch.violation), .objective_0(in_ch.objective_0),
    .objective_1(in_ch.objective_1), .objective_2(in_ch.objective_2),
    .objective_3(in_ch.objective_3),
    .target_slot(out_ch.target_slot), .source_index(out_ch.source_index),
    .last_of_run(out_ch.last_of_run)
  );

  // Input and output never handshake in the same cycle
  assert property (@(posedge clk) disable iff (rst) !(in_ch.ready && out_ch.valid))
    else $error("load and pick overlap");

  // A load is never followed directly by another load
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("back-to-back load");

  // Results only leave in the emit phase; valid drops in the cycle after a non-last pick is taken
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=> !out_ch.valid)
    else $error("pick spacing");

endmodule

// File: test/feasibility_first_survivor_select_core_tb.sv
`timescale 1ns / 1ps

// Holds the expected picks of each run and checks the block's output against them.
class pick_scoreboard;
  int unsigned surv_count_reg;
  int unsigned obj_use_reg;
  logic signed [31:0] viol_mem [128];
  logic [33:0] fit_mem [128];
  logic [6:0] infeas_ord [128];
  logic [6:0] feas_ord [128];
  int unsigned loaded;
  int unsigned infeas_cnt;
  logic [13:0] picks_due [$];
  int unsigned mismatches;
  int unsigned picks_seen;

  function new();
    surv_count_reg = 64;
    obj_use_reg = 2;
    loaded = 0;
    infeas_cnt = 0;
    mismatches = 0;
    picks_seen = 0;
  endfunction

  function void write_reg(int unsigned idx, logic [31:0] val);
    if (idx == ffss_pkg::REG_SURV_COUNT) surv_count_reg = val[6:0];
    else if (idx == ffss_pkg::REG_OBJ_USE) obj_use_reg = val[2:0];
  endfunction

  // Store one candidate; on the closing load sort both groups and queue the picks.
  function void note_candidate(logic signed [31:0] v, logic signed [31:0] o0,
                               logic signed [31:0] o1, logic signed [31:0] o2,
                               logic signed [31:0] o3);
    int unsigned p, k, idx, fea, i, j, src;
    logic signed [35:0] acc;
    logic signed [31:0] objs [4];
    logic [6:0] t;
    p = (surv_count_reg < 1) ? 1 : (surv_count_reg > 64) ? 64 : surv_count_reg;
    k = (obj_use_reg < 1) ? 1 : (obj_use_reg > 4) ? 4 : obj_use_reg;
    idx = (loaded >= 128) ? 127 : loaded;
    objs[0] = o0; objs[1] = o1; objs[2] = o2; objs[3] = o3;
    viol_mem[idx] = v;
    acc = 36'(o0);
    for (j = 1; j < k; j++)
      acc += (objs[j] < 0) ? -36'(objs[j]) : 36'(objs[j]);
    fit_mem[idx] = 34'((acc < 0) ? -acc : acc);
    if (v < 0) begin
      infeas_ord[infeas_cnt & 127] = 7'(idx);
      infeas_cnt++;
    end else begin
      feas_ord[(idx - infeas_cnt) & 127] = 7'(idx);
    end
    loaded = idx + 1;
    if (loaded < 2 * p) return;
    fea = loaded - infeas_cnt;
    for (i = 0; i + 1 < infeas_cnt; i++)
      for (j = i + 1; j < infeas_cnt; j++)
        if (viol_mem[infeas_ord[i]] < viol_mem[infeas_ord[j]]) begin
          t = infeas_ord[i]; infeas_ord[i] = infeas_ord[j]; infeas_ord[j] = t;
        end
    for (i = 0; i + 1 < fea; i++)
      for (j = i + 1; j < fea; j++)
        if (fit_mem[feas_ord[i]] > fit_mem[feas_ord[j]]) begin
          t = feas_ord[i]; feas_ord[i] = feas_ord[j]; feas_ord[j] = t;
        end
    for (i = 0; i < p; i++) begin
      src = (i < fea) ? feas_ord[i & 127] : infeas_ord[(i - fea) & 127];
      picks_due.push_back({6'(i), 7'(src), 1'(i + 1 == p)});
    end
    loaded = 0;
    infeas_cnt = 0;
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task check_pick(logic [5:0] slot, logic [6:0] src, logic last);
    logic [13:0] e;
    picks_seen++;
    if (picks_due.size() == 0) begin
      report($sformatf("unexpected pick slot %0d src %0d", slot, src));
      return;
    end
    e = picks_due.pop_front();
    if (slot !== e[13:8]) report($sformatf("target_slot %0d want %0d", slot, e[13:8]));
    if (src !== e[7:1]) report($sformatf("source_index %0d want %0d slot %0d", src, e[7:1], slot));
    if (last !== e[0]) report($sformatf("last_of_run %0b want %0b slot %0d", last, e[0], slot));
  endtask
endclass

module feasibility_first_survivor_select_core_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int unsigned cand_sent = 0;
  int unsigned cfg_phase;
  bit stall_free = 1'b0;

  ffss_in_if  in_ch ();
  ffss_out_if out_ch ();

  pick_scoreboard board = new();

  feasibility_first_survivor_select_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.violation = '0;
    in_ch.objective_0 = '0;
    in_ch.objective_1 = '0;
    in_ch.objective_2 = '0;
    in_ch.objective_3 = '0;
    out_ch.ready = 1'b0;
  end

  // Sink side: random stall per pick, check on each accepted transaction.
  initial begin
    int unsigned w;
    @(posedge clk);
    while (1) begin
      w = stall_free ? 0 : $urandom_range(0, 18);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      board.check_pick(out_ch.target_slot, out_ch.source_index, out_ch.last_of_run);
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    in_ch.valid <= 1'b0;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Send one candidate after a random gap; wait for its acceptance.
  task automatic send_cand(input logic [31:0] v, input logic [31:0] o0,
                           input logic [31:0] o1, input logic [31:0] o2,
                           input logic [31:0] o3);
    int unsigned w;
    w = stall_free ? 0 : $urandom_range(0, 18);
    if (w != 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.violation <= v; in_ch.objective_0 <= o0; in_ch.objective_1 <= o1;
    in_ch.objective_2 <= o2; in_ch.objective_3 <= o3;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_candidate(v, o0, o1, o2, o3);
    cand_sent++;
  endtask

  function automatic logic [31:0] pick_value(input int unsigned mode);
    case (mode)
      0: pick_value = 32'h8000_0000;
      1: pick_value = 32'h7fff_ffff;
      2: pick_value = 32'(int'($urandom_range(0, 6)) - 3);
      3: pick_value = 32'(int'($urandom_range(0, 8)) << 16);
      default: pick_value = $urandom;
    endcase
  endfunction

  task automatic random_cand();
    logic [31:0] v;
    v = pick_value($urandom_range(0, 5));
    send_cand(v, pick_value($urandom_range(0, 5)), pick_value($urandom_range(0, 5)),
              pick_value($urandom_range(0, 5)), pick_value($urandom_range(0, 5)));
  endtask

  // Wait until every queued pick has come back, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.picks_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int unsigned p, n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: tiny runs with field extremes, ties and all-infeasible groups.
    write_reg(ffss_pkg::REG_SURV_COUNT, 32'd2);
    write_reg(ffss_pkg::REG_OBJ_USE, 32'd4);
    send_cand(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_cand(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_cand(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
    send_cand(32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    send_cand(32'hffff_ffff, 32'h1, 32'h0, 32'h0, 32'h0);
    send_cand(32'hffff_ffff, 32'h2, 32'h0, 32'h0, 32'h0);
    send_cand(32'h8000_0000, 32'h3, 32'h0, 32'h0, 32'h0);
    send_cand(32'hffff_fffe, 32'h4, 32'h0, 32'h0, 32'h0);
    drain();
    // Out-of-range register values saturate.
    write_reg(ffss_pkg::REG_SURV_COUNT, 32'd0);
    write_reg(ffss_pkg::REG_OBJ_USE, 32'd0);
    send_cand(32'h5, 32'h5, 32'h9, 32'h9, 32'h9);
    send_cand(32'h5, 32'hffff_fffb, 32'h9, 32'h9, 32'h9);
    drain();
    write_reg(ffss_pkg::REG_SURV_COUNT, 32'hff);
    write_reg(ffss_pkg::REG_OBJ_USE, 32'd7);
    // Survivor count lowered mid-run; objectives changed mid-run too.
    write_reg(ffss_pkg::REG_SURV_COUNT, 32'd4);
    repeat (3) random_cand();
    write_reg(ffss_pkg::REG_OBJ_USE, 32'd1);
    repeat (2) random_cand();
    write_reg(ffss_pkg::REG_SURV_COUNT, 32'd2);
    random_cand();
    drain();

    // Random runs, mostly small, a few at full size.
    cfg_phase = 0;
    while (cand_sent < 330) begin
      cfg_phase++;
      p = (cfg_phase % 7 == 0) ? 64 : $urandom_range(1, 8);
      if (cfg_phase % 11 == 0) p = $urandom_range(65, 127);
      write_reg(ffss_pkg::REG_SURV_COUNT, 32'(p));
      write_reg(ffss_pkg::REG_OBJ_USE, 32'($urandom_range(0, 7)));
      stall_free = (cfg_phase % 5 == 0);
      n = 2 * ((p > 64) ? 64 : p);
      repeat (n) random_cand();
      drain();
    end
    stall_free = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d candidates in %0d runs, %0d picks checked",
             cand_sent, cfg_phase, board.picks_seen);
    if (board.mismatches == 0 && board.picks_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule

// File: filelist.f
design/ffss_pkg.sv
design/ffss_if.sv
design/ffss_ram.sv
design/ffss_ctrl.sv
design/ffss_dp.sv
design/feasibility_first_survivor_select_core.sv
test/feasibility_first_survivor_select_core_tb.sv
